// ----- rtl/tds_pkg.sv -----
package tds_pkg;

	localparam int MAX_ROWS = 64;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int IDX_W = 6;
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int QUO_W = DATA_WIDTH + FRAC_BITS;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		data_t sub_diag;
		data_t main_diag;
		data_t super_diag;
		data_t rhs_value;
		logic final_row;
	} row_t;

	typedef struct packed {
		data_t solution_value;
		logic [IDX_W-1:0] row_index;
		logic singular;
		logic last_out;
	} sol_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sub;
		logic div_init;
		logic div_step;
		logic store;
		logic emit;
		logic rd;
		logic bmul;
		logic bsub;
		logic clear;
		logic [ROW_W-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic [DATA_WIDTH-1:0] mag(input data_t v);
		logic [DATA_WIDTH-1:0] m;
		m = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

	// Sign and magnitude to a value saturated to the data range.
	function automatic data_t sat_mag(input logic neg, input logic [PROD_W-1:0] m);
		logic [PROD_W-1:0] lim;
		data_t r;
		lim = {{(PROD_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
		if (neg) begin
			if (m > lim + 1'b1)
				r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
			else
				r = ~m[DATA_WIDTH-1:0] + 1'b1;
		end else begin
			if (m > lim)
				r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
			else
				r = m[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic data_t fx_mul(input data_t x, input data_t y);
		logic [PROD_W-1:0] p;
		p = PROD_W'(mag(x)) * PROD_W'(mag(y));
		return sat_mag(x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1], p >> FRAC_BITS);
	endfunction

	function automatic data_t fx_sub(input data_t x, input data_t y);
		logic [DATA_WIDTH:0] d;
		data_t r;
		d = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
		if (d[DATA_WIDTH] != d[DATA_WIDTH-1])
			r = d[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		else
			r = d[DATA_WIDTH-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/tds_ram.sv -----
module tds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

endmodule

// ----- rtl/tds_ctrl.sv -----
module tds_ctrl import tds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic row_valid,
	input logic final_row,
	output logic row_stall,
	input status_t status,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_SUB, S_DIVI, S_DIV, S_STORE, S_EMIT, S_RD, S_BMUL, S_BSUB
	} state_t;

	state_t state_q;
	logic [ROW_W-1:0] row_q;
	logic last_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			last_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (row_valid) begin
						last_q <= final_row || (row_q == ROW_W'(MAX_ROWS - 1));
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_SUB;
				S_SUB: state_q <= S_DIVI;
				S_DIVI: begin
					cnt_q <= CNT_W'(DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_STORE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_STORE: begin
					if (last_q) begin
						state_q <= S_EMIT;
					end else begin
						row_q <= row_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						if (row_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							row_q <= row_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_BMUL;
				S_BMUL: state_q <= S_BSUB;
				S_BSUB: state_q <= S_EMIT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign row_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.addr = row_q;
		cmd.load = (state_q == S_IDLE) && row_valid;
		cmd.mul = (state_q == S_MUL);
		cmd.sub = (state_q == S_SUB);
		cmd.div_init = (state_q == S_DIVI);
		cmd.div_step = (state_q == S_DIV);
		cmd.store = (state_q == S_STORE);
		cmd.emit = (state_q == S_EMIT) && status.out_free;
		cmd.clear = cmd.emit && (row_q == '0);
		cmd.rd = (state_q == S_RD);
		cmd.bmul = (state_q == S_BMUL);
		cmd.bsub = (state_q == S_BSUB);
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free) else $error("emit while output register busy");
	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && !row_stall) |=> row_stall) else $error("second row taken during a solve");
	a_end_resets_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (row_q == '0) && !row_stall) else $error("run did not end cleanly");
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> cmd.div_step && (cnt_q == CNT_W'(DIV_STEPS - 1)))
		else $error("divider count not loaded");

endmodule

// ----- rtl/tds_dp.sv -----
module tds_dp import tds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input row_t row_data,
	input cmd_t cmd,
	output status_t status,
	output logic sol_valid,
	input logic sol_stall,
	output sol_t sol_data
);

	data_t a_q, b_q, c_q, d_q;
	data_t prev_s_q, prev_r_q;
	data_t p1_q, p2_q;
	data_t den_q, num_q;
	data_t x_q, prod_q;
	logic singular_q;
	logic zero_q, neg1_q, neg2_q;
	logic [DATA_WIDTH-1:0] dm_q, rem1_q, rem2_q;
	logic [QUO_W-1:0] n1_q, n2_q, q1_q, q2_q;
	logic [2*DATA_WIDTH-1:0] rd_data;
	sol_t sol_q;
	logic sol_valid_q;
	data_t cs, ds;
	logic [DATA_WIDTH:0] t1, t2;
	logic ge1, ge2;

	// One restoring step for each of the two quotients over the shared divisor.
	assign t1 = {rem1_q, n1_q[QUO_W-1]};
	assign t2 = {rem2_q, n2_q[QUO_W-1]};
	assign ge1 = (t1 >= {1'b0, dm_q});
	assign ge2 = (t2 >= {1'b0, dm_q});

	always_comb begin
		if (zero_q) begin
			cs = '0;
			ds = '0;
		end else begin
			cs = sat_mag(neg1_q, PROD_W'(q1_q));
			ds = sat_mag(neg2_q, PROD_W'(q2_q));
		end
	end

	tds_ram #(.WIDTH(2 * DATA_WIDTH), .DEPTH(MAX_ROWS)) u_store (
		.clk(clk),
		.we(cmd.store),
		.waddr(cmd.addr),
		.wdata({cs, ds}),
		.re(cmd.rd),
		.raddr(cmd.addr),
		.rdata_q(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= row_data.sub_diag;
			b_q <= row_data.main_diag;
			c_q <= row_data.super_diag;
			d_q <= row_data.rhs_value;
		end
		if (cmd.mul) begin
			p1_q <= fx_mul(a_q, prev_s_q);
			p2_q <= fx_mul(a_q, prev_r_q);
		end
		if (cmd.sub) begin
			den_q <= fx_sub(b_q, p1_q);
			num_q <= fx_sub(d_q, p2_q);
		end
		if (cmd.div_init) begin
			zero_q <= (den_q == '0);
			neg1_q <= c_q[DATA_WIDTH-1] ^ den_q[DATA_WIDTH-1];
			neg2_q <= num_q[DATA_WIDTH-1] ^ den_q[DATA_WIDTH-1];
			dm_q <= mag(den_q);
			n1_q <= {mag(c_q), {FRAC_BITS{1'b0}}};
			n2_q <= {mag(num_q), {FRAC_BITS{1'b0}}};
			rem1_q <= '0;
			rem2_q <= '0;
			q1_q <= '0;
			q2_q <= '0;
		end
		if (cmd.div_step) begin
			n1_q <= n1_q << 1;
			n2_q <= n2_q << 1;
			rem1_q <= ge1 ? DATA_WIDTH'(t1 - {1'b0, dm_q}) : DATA_WIDTH'(t1);
			rem2_q <= ge2 ? DATA_WIDTH'(t2 - {1'b0, dm_q}) : DATA_WIDTH'(t2);
			q1_q <= {q1_q[QUO_W-2:0], ge1};
			q2_q <= {q2_q[QUO_W-2:0], ge2};
		end
		if (cmd.bmul)
			prod_q <= fx_mul(rd_data[2*DATA_WIDTH-1:DATA_WIDTH], x_q);
		if (cmd.store)
			x_q <= ds;
		else if (cmd.bsub)
			x_q <= fx_sub(rd_data[DATA_WIDTH-1:0], prod_q);
		if (cmd.emit) begin
			sol_q.solution_value <= x_q;
			sol_q.row_index <= IDX_W'(cmd.addr);
			sol_q.singular <= singular_q;
			sol_q.last_out <= (cmd.addr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_s_q <= '0;
			prev_r_q <= '0;
			singular_q <= 1'b0;
			sol_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				prev_s_q <= '0;
				prev_r_q <= '0;
				singular_q <= 1'b0;
			end else if (cmd.store) begin
				prev_s_q <= cs;
				prev_r_q <= ds;
				if (zero_q)
					singular_q <= 1'b1;
			end
			if (cmd.emit)
				sol_valid_q <= 1'b1;
			else if (!sol_stall)
				sol_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !sol_valid_q || !sol_stall;
	assign sol_valid = sol_valid_q;
	assign sol_data = sol_q;

endmodule

// ----- rtl/tridiagonal_system_solver.sv -----
// Tridiagonal system solver using the Thomas algorithm in signed Q16.16.
// Rows enter on the row channel (row_valid, row_stall, row_data), one
// transaction per row, with final_row set on the last row of a system.
// A system that reaches 64 rows ends on its 64th row regardless of final_row.
// Each row passes through the forward sweep: input capture, two products, two
// differences, divider setup, a bit-serial divider that forms both quotients
// at once, and a store to the row memory.
// row_stall stays high while a row or a back substitution is in progress.
// After the last row, solutions leave on the sol channel (sol_valid,
// sol_stall, sol_data) from the last row down to row zero, one transaction
// per row. The last row's solution is registered from the emit state that
// follows its store, and each further solution follows the memory read,
// multiply and subtract of each back-substitution step.
// A stall on the sol channel holds the output register and pauses the back
// substitution; a new row is taken once the row-zero result is registered.
// Reset clears the row count, the carried quotients and the singular flag,
// and empties the output register; the row memory needs no clearing.
module tridiagonal_system_solver import tds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic row_valid,
	output logic row_stall,
	input row_t row_data,
	output logic sol_valid,
	input logic sol_stall,
	output sol_t sol_data
);

	cmd_t cmd;
	status_t status;

	tds_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.row_valid(row_valid),
		.final_row(row_data.final_row),
		.row_stall(row_stall),
		.status(status),
		.cmd(cmd)
	);

	tds_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.row_data(row_data),
		.cmd(cmd),
		.status(status),
		.sol_valid(sol_valid),
		.sol_stall(sol_stall),
		.sol_data(sol_data)
	);

endmodule

// ----- verif/tridiagonal_system_solver_chk.sv -----
module tridiagonal_system_solver_chk import tds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic row_valid,
	input logic row_stall,
	input row_t row_data,
	input logic sol_valid,
	input logic sol_stall,
	input sol_t sol_data,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	data_t sweep_super [MAX_ROWS];
	data_t sweep_rhs [MAX_ROWS];
	int rows_in;
	data_t carry_super;
	data_t carry_rhs;
	logic pivot_zero;
	sol_t solution_q[$];

	function automatic data_t sat_wide(input logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'sh7fffffff;
		if (v < -128'sd2147483648)
			return 32'sh80000000;
		return data_t'(v);
	endfunction

	function automatic data_t q_mul(input data_t x, input data_t y);
		logic signed [127:0] p;
		p = (128'(signed'(x)) * 128'(signed'(y)));
		p = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
		return sat_wide(p);
	endfunction

	function automatic data_t q_div(input data_t x, input data_t y);
		logic signed [127:0] n;
		logic signed [127:0] dv;
		logic [127:0] mq;
		logic neg;
		n = 128'(signed'(x));
		dv = 128'(signed'(y));
		neg = (n < 0) != (dv < 0);
		mq = ((n < 0 ? -n : n) << FRAC_BITS) / (dv < 0 ? -dv : dv);
		return sat_wide(neg ? -$signed(mq) : $signed(mq));
	endfunction

	function automatic data_t q_sub(input data_t x, input data_t y);
		return sat_wide(128'(signed'(x)) - 128'(signed'(y)));
	endfunction

	task automatic report(input string what, input sol_t got, input sol_t want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	task automatic sweep_row(input row_t r);
		int row;
		data_t den, num, cs, ds, x;
		sol_t s;
		row = rows_in;
		if (row == 0) begin
			den = r.main_diag;
			num = r.rhs_value;
		end else begin
			den = q_sub(r.main_diag, q_mul(r.sub_diag, carry_super));
			num = q_sub(r.rhs_value, q_mul(r.sub_diag, carry_rhs));
		end
		if (den == 0) begin
			pivot_zero = 1'b1;
			cs = '0;
			ds = '0;
		end else begin
			cs = q_div(r.super_diag, den);
			ds = q_div(num, den);
		end
		sweep_super[row] = cs;
		sweep_rhs[row] = ds;
		carry_super = cs;
		carry_rhs = ds;
		if (!r.final_row && row != MAX_ROWS - 1) begin
			rows_in = row + 1;
			return;
		end
		x = ds;
		for (int i = row; i >= 0; i--) begin
			if (i < row)
				x = q_sub(sweep_rhs[i], q_mul(sweep_super[i], x));
			s.solution_value = x;
			s.row_index = i[IDX_W-1:0];
			s.singular = pivot_zero;
			s.last_out = (i == 0);
			solution_q.push_back(s);
		end
		rows_in = 0;
		carry_super = '0;
		carry_rhs = '0;
		pivot_zero = 1'b0;
	endtask

	assign pending = solution_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in = 0;
			carry_super = '0;
			carry_rhs = '0;
			pivot_zero = 1'b0;
			fail_count = 0;
			solution_q.delete();
		end else begin
			if (sol_valid && !sol_stall) begin
				if (solution_q.size() == 0)
					report("unexpected", sol_data, '0);
				else if (solution_q[0] != sol_data)
					report("field", sol_data, solution_q.pop_front());
				else
					void'(solution_q.pop_front());
			end
			if (row_valid && !row_stall)
				sweep_row(row_data);
		end
	end
endmodule

// ----- verif/tridiagonal_system_solver_tb.sv -----
module tridiagonal_system_solver_tb import tds_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic row_valid;
	logic row_stall;
	row_t row_data;
	logic sol_valid;
	logic sol_stall;
	sol_t sol_data;
	int fail_count;
	int pending;
	int send_idle;
	int recv_idle;
	int hold_cycles;
	longint cycle_count;

	tridiagonal_system_solver u_dut (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_stall(row_stall), .row_data(row_data),
		.sol_valid(sol_valid), .sol_stall(sol_stall), .sol_data(sol_data)
	);

	tridiagonal_system_solver_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_stall(row_stall), .row_data(row_data),
		.sol_valid(sol_valid), .sol_stall(sol_stall), .sol_data(sol_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 3000000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		sol_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				sol_stall <= 1'b1;
				hold_cycles--;
			end else begin
				sol_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	function automatic data_t pick_value(input int mode);
		case (mode)
		0: return 32'sh80000000;
		1: return 32'sh7fffffff;
		2: return '0;
		3: return data_t'($urandom);
		default: return data_t'($urandom_range(262144) - 131072);
		endcase
	endfunction

	task automatic send_row(input data_t a, input data_t b, input data_t c,
		input data_t d, input logic fin);
		row_t r;
		r.sub_diag = a;
		r.main_diag = b;
		r.super_diag = c;
		r.rhs_value = d;
		r.final_row = fin;
		while ($urandom_range(99) < send_idle) begin
			row_valid <= 1'b0;
			@(posedge clk);
		end
		row_valid <= 1'b1;
		row_data <= r;
		@(posedge clk);
		while (row_stall)
			@(posedge clk);
	endtask

	task automatic send_system(input int n, input int mode);
		int m;
		for (int i = 0; i < n; i++) begin
			m = (mode == 0) ? $urandom_range(4) : 4;
			send_row(pick_value(m), data_t'($urandom_range(0, 1) ? 32'sh40000 :
				-32'sh30000) + pick_value(4), pick_value(m), pick_value(m), i == n - 1);
		end
	endtask

	initial begin
		row_valid = 1'b0;
		row_data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1);
		send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);
		send_row('0, '0, 32'sh10000, 32'sh10000, 1'b0);
		send_row(32'sh10000, 32'sh20000, '0, 32'sh10000, 1'b1);
		send_row(32'shffffffff, 32'sh1, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_row(32'sh10000, 32'sh10000, 32'sh10000, 32'shffffffff, 1'b1);
		send_row(32'sh10000, 32'sh20000, 32'sh10000, 32'sh30000, 1'b0);
		send_row(32'sh10000, 32'sh10000, 32'sh10000, 32'sh30000, 1'b0);
		send_row(32'sh10000, 32'sh20000, 32'sh10000, 32'sh30000, 1'b1);
		for (int i = 0; i < 64; i++)
			send_row(data_t'($urandom_range(65536)), 32'sh40000, data_t'($urandom), 32'sh10000,
				1'b0);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1) ? 76 : 0;
			recv_idle = (ph == 0) ? 76 : (ph == 1) ? 38 : 0;
			if (ph == 2)
				hold_cycles = 2000;
			for (int k = 0; k < 2; k++)
				send_system($urandom_range(1, 5), $urandom_range(1));
			send_system($urandom_range(6, 12), 0);
		end
		row_valid <= 1'b0;
		send_idle = 0;
		recv_idle = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
